// File: rtl/poly_voice_allocator_macros.svh
// Assertion macros used by the voice allocator top level.
`ifndef POLY_VOICE_ALLOCATOR_MACROS_SVH
`define POLY_VOICE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define PVA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define PVA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pva_pkg.sv
// Shared types and constants of the polyphonic voice allocator.
package pva_pkg;

  localparam int unsigned DEFAULT_NUM_VOICES = 9;

  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned CH_W    = 4;
  localparam int unsigned NOTE_W  = 7;
  localparam int unsigned VEL_W   = 7;
  localparam int unsigned VOICE_W = 4;

  localparam logic [CH_W-1:0] DRUM_RESET = 4'd9;

  typedef enum logic [FUNC_W-1:0] {
    FN_NOTE_ON  = 3'd0,
    FN_NOTE_OFF = 3'd1,
    FN_PEDAL    = 3'd2,
    FN_ALL_OFF  = 3'd3,
    FN_SILENCE  = 3'd4
  } pva_func_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_ON,
    S_PLACE,
    S_SCAN_OFF,
    S_OUTER,
    S_PEDAL,
    S_SILENCE,
    S_FLUSH
  } pva_state_e;

  // One voice entry as seen on the read port of the voice file.
  typedef struct packed {
    logic [CH_W-1:0]   ch;
    logic [NOTE_W-1:0] note;
    logic              keyed;
    logic              held;
  } pva_entry_t;

  // Write command from the sequencer to the voice file.
  typedef struct packed {
    logic on_write;
    logic age_move;
    logic clr_keyed;
    logic clr_held;
    logic set_held;
  } pva_wr_t;

endpackage

// File: rtl/pva_voice_file.sv
// Per-voice state: channel, note, key and hold flags, and age rank.
module pva_voice_file #(
  parameter int unsigned NUM_VOICES = pva_pkg::DEFAULT_NUM_VOICES,
  localparam int unsigned IW = $clog2(NUM_VOICES)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [IW-1:0]               rd_idx_i,
  output pva_pkg::pva_entry_t         rd_entry_o,
  output logic [IW-1:0]               rd_rank_o,
  input  pva_pkg::pva_wr_t            wr_i,
  input  logic [IW-1:0]               wr_idx_i,
  input  logic [IW-1:0]               wr_rank_i,
  input  logic [pva_pkg::CH_W-1:0]    wr_ch_i,
  input  logic [pva_pkg::NOTE_W-1:0]  wr_note_i
);

  logic [pva_pkg::CH_W-1:0]   ch_q    [NUM_VOICES];
  logic [pva_pkg::NOTE_W-1:0] note_q  [NUM_VOICES];
  logic                       keyed_q [NUM_VOICES];
  logic                       held_q  [NUM_VOICES];
  // Rank 0 is the oldest voice, NUM_VOICES-1 the youngest.
  logic [IW-1:0]              rank_q  [NUM_VOICES];

  assign rd_entry_o.ch    = ch_q[rd_idx_i];
  assign rd_entry_o.note  = note_q[rd_idx_i];
  assign rd_entry_o.keyed = keyed_q[rd_idx_i];
  assign rd_entry_o.held  = held_q[rd_idx_i];
  assign rd_rank_o        = rank_q[rd_idx_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_VOICES; k++) begin
        ch_q[k]    <= '0;
        note_q[k]  <= '0;
        keyed_q[k] <= 1'b0;
        held_q[k]  <= 1'b0;
        rank_q[k]  <= IW'(k);
      end
    end else begin
      for (int k = 0; k < NUM_VOICES; k++) begin
        if (wr_idx_i == IW'(k)) begin
          if (wr_i.on_write) begin
            ch_q[k]    <= wr_ch_i;
            note_q[k]  <= wr_note_i;
            keyed_q[k] <= 1'b1;
            held_q[k]  <= 1'b0;
          end
          if (wr_i.clr_keyed) begin
            keyed_q[k] <= 1'b0;
          end
          if (wr_i.clr_held) begin
            held_q[k] <= 1'b0;
          end
          if (wr_i.set_held) begin
            held_q[k] <= 1'b1;
          end
        end
        // Moving a voice to the young end closes the gap it leaves behind.
        if (wr_i.on_write && wr_i.age_move) begin
          if (wr_idx_i == IW'(k)) begin
            rank_q[k] <= IW'(NUM_VOICES - 1);
          end else if (rank_q[k] > wr_rank_i) begin
            rank_q[k] <= rank_q[k] - IW'(1);
          end
        end
      end
    end
  end

endmodule

// File: rtl/pva_ctrl.sv
// Sequencer that scans the voices one per cycle and orders the results.
module pva_ctrl #(
  parameter int unsigned NUM_VOICES = pva_pkg::DEFAULT_NUM_VOICES,
  localparam int unsigned IW = $clog2(NUM_VOICES)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [pva_pkg::FUNC_W-1:0]  func_i,
  input  logic [pva_pkg::CH_W-1:0]    midi_channel_i,
  input  logic [pva_pkg::NOTE_W-1:0]  note_number_i,
  input  logic [pva_pkg::VEL_W-1:0]   velocity_i,
  input  logic [pva_pkg::VEL_W-1:0]   pedal_value_i,
  input  logic [pva_pkg::CH_W-1:0]    drum_channel_i,
  output logic [IW-1:0]               rd_idx_o,
  input  pva_pkg::pva_entry_t         rd_entry_i,
  input  logic [IW-1:0]               rd_rank_i,
  output pva_pkg::pva_wr_t            wr_o,
  output logic [IW-1:0]               wr_idx_o,
  output logic [IW-1:0]               wr_rank_o,
  output logic [pva_pkg::CH_W-1:0]    wr_ch_o,
  output logic [pva_pkg::NOTE_W-1:0]  wr_note_o,
  output logic                        result_strobe_o,
  output logic [pva_pkg::VOICE_W-1:0] voice_o,
  output logic                        key_on_o,
  output logic [pva_pkg::NOTE_W-1:0]  out_note_o,
  output logic                        stolen_o,
  output logic                        last_o
);

  pva_pkg::pva_state_e state_q, state_d;
  pva_pkg::pva_func_e  fn;

  logic [IW-1:0]              idx_q, outer_q;
  logic [pva_pkg::CH_W-1:0]   op_ch_q;
  logic [pva_pkg::NOTE_W-1:0] op_note_q;
  logic                       aoff_q;
  logic                       pedal_down_q;

  logic          hit_q, free_q, drum_q;
  logic [IW-1:0] hit_idx_q, free_idx_q, drum_idx_q, old_idx_q;
  logic [IW-1:0] free_rank_q, drum_rank_q;

  logic                       pend_valid_q;
  logic [IW-1:0]              pend_voice_q;
  logic                       pend_key_on_q;
  logic [pva_pkg::NOTE_W-1:0] pend_note_q;
  logic                       pend_stolen_q;

  logic                        out_valid_q;
  logic [pva_pkg::VOICE_W-1:0] out_voice_q;
  logic                        out_key_on_q;
  logic [pva_pkg::NOTE_W-1:0]  out_note_q;
  logic                        out_stolen_q;
  logic                        out_last_q;

  logic accept, note_on_go, off_go;
  logic idx_last, outer_last;
  logic match, ch_eq, drum_eq;
  logic off_done;

  logic                       emit, flush;
  logic [IW-1:0]              emit_voice;
  logic                       emit_key_on;
  logic [pva_pkg::NOTE_W-1:0] emit_note;
  logic                       emit_stolen;
  logic [IW-1:0]              sel_idx, sel_rank;

  assign fn         = pva_pkg::pva_func_e'(func_i);
  assign accept     = start && (state_q == pva_pkg::S_IDLE);
  assign busy       = (state_q != pva_pkg::S_IDLE);
  assign note_on_go = (fn == pva_pkg::FN_NOTE_ON) && (velocity_i != '0);
  assign off_go     = ((fn == pva_pkg::FN_NOTE_ON) && (velocity_i == '0)) ||
                      (fn == pva_pkg::FN_NOTE_OFF);

  assign idx_last   = (idx_q == IW'(NUM_VOICES - 1));
  assign outer_last = (outer_q == IW'(NUM_VOICES - 1));

  // Shared compare unit, fed by the single voice read port.
  assign rd_idx_o = (state_q == pva_pkg::S_OUTER) ? outer_q : idx_q;
  assign ch_eq    = (rd_entry_i.ch == op_ch_q);
  assign drum_eq  = (rd_entry_i.ch == drum_channel_i);
  assign match    = ch_eq && (rd_entry_i.note == op_note_q);
  assign off_done = match || idx_last;

  // Note-on choice: reuse, else first free, else youngest drum voice, else oldest.
  always_comb begin
    priority if (hit_q) begin
      sel_idx  = hit_idx_q;
      sel_rank = '0;
    end else if (free_q) begin
      sel_idx  = free_idx_q;
      sel_rank = free_rank_q;
    end else if (drum_q) begin
      sel_idx  = drum_idx_q;
      sel_rank = drum_rank_q;
    end else begin
      sel_idx  = old_idx_q;
      sel_rank = '0;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pva_pkg::S_IDLE: begin
        if (accept) begin
          if (note_on_go) begin
            state_d = pva_pkg::S_SCAN_ON;
          end else if (off_go) begin
            state_d = pva_pkg::S_SCAN_OFF;
          end else if (fn == pva_pkg::FN_PEDAL && pedal_value_i == '0) begin
            state_d = pva_pkg::S_PEDAL;
          end else if (fn == pva_pkg::FN_ALL_OFF) begin
            state_d = pva_pkg::S_OUTER;
          end else if (fn == pva_pkg::FN_SILENCE) begin
            state_d = pva_pkg::S_SILENCE;
          end
        end
      end
      pva_pkg::S_SCAN_ON: begin
        if (idx_last) state_d = pva_pkg::S_PLACE;
      end
      pva_pkg::S_PLACE: begin
        state_d = pva_pkg::S_FLUSH;
      end
      pva_pkg::S_SCAN_OFF: begin
        if (off_done) begin
          state_d = (aoff_q && !outer_last) ? pva_pkg::S_OUTER : pva_pkg::S_FLUSH;
        end
      end
      pva_pkg::S_OUTER: begin
        if (ch_eq) begin
          state_d = pva_pkg::S_SCAN_OFF;
        end else if (outer_last) begin
          state_d = pva_pkg::S_FLUSH;
        end
      end
      pva_pkg::S_PEDAL, pva_pkg::S_SILENCE: begin
        if (idx_last) state_d = pva_pkg::S_FLUSH;
      end
      pva_pkg::S_FLUSH: begin
        state_d = pva_pkg::S_IDLE;
      end
      default: begin
        state_d = pva_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    wr_o        = '0;
    wr_idx_o    = idx_q;
    wr_rank_o   = sel_rank;
    wr_ch_o     = op_ch_q;
    wr_note_o   = op_note_q;
    emit        = 1'b0;
    flush       = 1'b0;
    emit_voice  = idx_q;
    emit_key_on = 1'b0;
    emit_note   = rd_entry_i.note;
    emit_stolen = 1'b0;
    unique case (state_q)
      pva_pkg::S_PLACE: begin
        wr_o.on_write = 1'b1;
        wr_o.age_move = !hit_q;
        wr_idx_o      = sel_idx;
        emit          = 1'b1;
        emit_voice    = sel_idx;
        emit_key_on   = 1'b1;
        emit_note     = op_note_q;
        emit_stolen   = !hit_q && !free_q;
      end
      pva_pkg::S_SCAN_OFF: begin
        if (match) begin
          if (pedal_down_q) begin
            wr_o.set_held = 1'b1;
          end else begin
            wr_o.clr_keyed = 1'b1;
            wr_o.clr_held  = 1'b1;
            emit           = 1'b1;
          end
        end
      end
      pva_pkg::S_PEDAL: begin
        if (rd_entry_i.held) begin
          wr_o.clr_keyed = 1'b1;
          wr_o.clr_held  = 1'b1;
          emit           = 1'b1;
        end
      end
      pva_pkg::S_SILENCE: begin
        wr_o.clr_keyed = 1'b1;
        emit           = 1'b1;
      end
      pva_pkg::S_FLUSH: begin
        flush = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pva_pkg::S_IDLE;
      pedal_down_q <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      hit_q        <= 1'b0;
      free_q       <= 1'b0;
      drum_q       <= 1'b0;
      aoff_q       <= 1'b0;
      idx_q        <= '0;
      outer_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= 1'b0;

      unique case (state_q)
        pva_pkg::S_IDLE: begin
          if (accept) begin
            idx_q   <= '0;
            outer_q <= '0;
            aoff_q  <= (fn == pva_pkg::FN_ALL_OFF);
            hit_q   <= 1'b0;
            free_q  <= 1'b0;
            drum_q  <= 1'b0;
            if (fn == pva_pkg::FN_PEDAL) begin
              pedal_down_q <= (pedal_value_i != '0);
            end
          end
        end
        pva_pkg::S_SCAN_ON: begin
          if (!hit_q && match && rd_entry_i.keyed) begin
            hit_q <= 1'b1;
          end
          if (!free_q && !rd_entry_i.keyed) begin
            free_q <= 1'b1;
          end
          if (drum_eq && (!drum_q || rd_rank_i > drum_rank_q)) begin
            drum_q <= 1'b1;
          end
          idx_q <= idx_last ? '0 : idx_q + IW'(1);
        end
        pva_pkg::S_SCAN_OFF: begin
          idx_q <= idx_q + IW'(1);
          if (off_done) begin
            outer_q <= outer_q + IW'(1);
          end
        end
        pva_pkg::S_OUTER: begin
          if (ch_eq) begin
            idx_q <= '0;
          end else begin
            outer_q <= outer_q + IW'(1);
          end
        end
        pva_pkg::S_PEDAL, pva_pkg::S_SILENCE: begin
          idx_q <= idx_q + IW'(1);
        end
        default: begin
        end
      endcase

      // A result waits in the pending stage until the next one, or the end of
      // the item, shows whether it is the final one.
      if (emit) begin
        pend_valid_q <= 1'b1;
        out_valid_q  <= pend_valid_q;
      end else if (flush) begin
        pend_valid_q <= 1'b0;
        out_valid_q  <= pend_valid_q;
      end
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_ch_q   <= midi_channel_i;
      op_note_q <= note_number_i;
    end
    if (state_q == pva_pkg::S_OUTER && ch_eq) begin
      op_note_q <= rd_entry_i.note;
    end
    if (state_q == pva_pkg::S_SCAN_ON) begin
      if (!hit_q && match && rd_entry_i.keyed) begin
        hit_idx_q <= idx_q;
      end
      if (!free_q && !rd_entry_i.keyed) begin
        free_idx_q  <= idx_q;
        free_rank_q <= rd_rank_i;
      end
      if (drum_eq && (!drum_q || rd_rank_i > drum_rank_q)) begin
        drum_idx_q  <= idx_q;
        drum_rank_q <= rd_rank_i;
      end
      if (rd_rank_i == '0) begin
        old_idx_q <= idx_q;
      end
    end
    if (emit) begin
      pend_voice_q  <= emit_voice;
      pend_key_on_q <= emit_key_on;
      pend_note_q   <= emit_note;
      pend_stolen_q <= emit_stolen;
    end
    if (emit || flush) begin
      out_voice_q  <= pva_pkg::VOICE_W'(pend_voice_q);
      out_key_on_q <= pend_key_on_q;
      out_note_q   <= pend_note_q;
      out_stolen_q <= pend_stolen_q;
      out_last_q   <= flush;
    end
  end

  assign result_strobe_o = out_valid_q;
  assign voice_o         = out_voice_q;
  assign key_on_o        = out_key_on_q;
  assign out_note_o      = out_note_q;
  assign stolen_o        = out_stolen_q;
  assign last_o          = out_last_q;

endmodule

// File: rtl/poly_voice_allocator.sv
// Top level of the polyphonic voice allocator.
// An event is taken when start is high while busy is low, and busy then stays
// high while the sequencer walks the voices, one voice per cycle through a
// single read port and compare unit. A note-on scans every voice and then
// places the note, a note-off scans until it finds its note or reaches the
// last voice, a pedal release or silence walks every voice, and an
// all-notes-off walks every voice, and each voice on the channel starts a
// fresh search for its note. Pedal down and unused function codes
// finish at once. Results leave at most one per cycle, each on result_strobe_o
// for a single cycle. A result is held back until the next result of the event,
// or the end of the event, is known, so the final one appears in the first
// cycle with busy low again. The receiver must take every result when it
// appears, and last_o marks the final one of an event. The drum channel
// register is written through the cfg channel, which is always ready, and
// should only be written while busy is low.
module poly_voice_allocator #(
  parameter int unsigned NUM_VOICES = pva_pkg::DEFAULT_NUM_VOICES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [pva_pkg::FUNC_W-1:0]  func_i,
  input  logic [pva_pkg::CH_W-1:0]    midi_channel_i,
  input  logic [pva_pkg::NOTE_W-1:0]  note_number_i,
  input  logic [pva_pkg::VEL_W-1:0]   velocity_i,
  input  logic [pva_pkg::VEL_W-1:0]   pedal_value_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [pva_pkg::CH_W-1:0]    cfg_data_i,
  output logic                        result_strobe_o,
  output logic [pva_pkg::VOICE_W-1:0] voice_o,
  output logic                        key_on_o,
  output logic [pva_pkg::NOTE_W-1:0]  out_note_o,
  output logic                        stolen_o,
  output logic                        last_o
);

  `include "poly_voice_allocator_macros.svh"

  localparam int unsigned IW = $clog2(NUM_VOICES);

  logic [pva_pkg::CH_W-1:0]   drum_q;
  logic [IW-1:0]              rd_idx, rd_rank, wr_idx, wr_rank;
  pva_pkg::pva_entry_t        rd_entry;
  pva_pkg::pva_wr_t           wr;
  logic [pva_pkg::CH_W-1:0]   wr_ch;
  logic [pva_pkg::NOTE_W-1:0] wr_note;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drum_q <= pva_pkg::DRUM_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      drum_q <= cfg_data_i;
    end
  end

  pva_voice_file #(
    .NUM_VOICES(NUM_VOICES)
  ) u_voice_file (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_idx_i  (rd_idx),
    .rd_entry_o(rd_entry),
    .rd_rank_o (rd_rank),
    .wr_i      (wr),
    .wr_idx_i  (wr_idx),
    .wr_rank_i (wr_rank),
    .wr_ch_i   (wr_ch),
    .wr_note_i (wr_note)
  );

  pva_ctrl #(
    .NUM_VOICES(NUM_VOICES)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .midi_channel_i (midi_channel_i),
    .note_number_i  (note_number_i),
    .velocity_i     (velocity_i),
    .pedal_value_i  (pedal_value_i),
    .drum_channel_i (drum_q),
    .rd_idx_o       (rd_idx),
    .rd_entry_i     (rd_entry),
    .rd_rank_i      (rd_rank),
    .wr_o           (wr),
    .wr_idx_o       (wr_idx),
    .wr_rank_o      (wr_rank),
    .wr_ch_o        (wr_ch),
    .wr_note_o      (wr_note),
    .result_strobe_o(result_strobe_o),
    .voice_o        (voice_o),
    .key_on_o       (key_on_o),
    .out_note_o     (out_note_o),
    .stolen_o       (stolen_o),
    .last_o         (last_o)
  );

  // A result is only produced by work that was in progress the cycle before.
  `PVA_ASSERT_IMP(a_result_after_work, result_strobe_o, $past(busy), "result without work")
  // The final result of an event is never followed directly by another.
  `PVA_ASSERT_NXT(a_gap_after_last, result_strobe_o && last_o, !result_strobe_o, "result after last")
  // A note-on with a nonzero velocity always occupies the sequencer.
  `PVA_ASSERT_NXT(a_note_on_busy, start && !busy && func_i == pva_pkg::FN_NOTE_ON && velocity_i != '0, busy, "note-on not started")

endmodule
